// ----- rtl/rt3_pkg.sv -----
// Shared constants for the 3x3 rank transform block.
`timescale 1ns / 1ps
`default_nettype none
package rt3_pkg;

  localparam int MAX_SIDE_DEF   = 1024;
  localparam int PIXEL_BITS_DEF = 16;

  localparam int CFG_W   = 11;
  localparam int IN_W    = 16;
  localparam int COORD_W = 10;
  localparam int COUNT_W = 4;

  localparam logic [CFG_W-1:0] SIDE_RESET = CFG_W'(3);
  localparam int               MIN_SIDE   = 3;

endpackage
`default_nettype wire

// ----- rtl/rt3_line_mem.sv -----
// Two-row line store memory with a registered read port and write-to-read forwarding.
`timescale 1ns / 1ps
`default_nettype none
module rt3_line_mem
  import rt3_pkg::*;
#(
  parameter int DEPTH = MAX_SIDE_DEF,
  parameter int WIDTH = 2 * PIXEL_BITS_DEF,
  parameter int AW    = $clog2(MAX_SIDE_DEF)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the entry written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rt3_window.sv -----
// 3x3 window registers and the count of neighbors smaller than the center.
`timescale 1ns / 1ps
`default_nettype none
module rt3_window
  import rt3_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         shift,
  input  wire logic signed [PIXEL_BITS-1:0] top,
  input  wire logic signed [PIXEL_BITS-1:0] mid,
  input  wire logic signed [PIXEL_BITS-1:0] bottom,
  output logic             [COUNT_W-1:0]    count
);

  logic signed [PIXEL_BITS-1:0] win [6];
  logic signed [PIXEL_BITS-1:0] nbr [8];
  logic        [COUNT_W-1:0]    sum;

  always_ff @(posedge clk) begin
    if (shift) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= bottom;
    end
  end

  always_comb begin
    nbr[0] = win[0];
    nbr[1] = win[1];
    nbr[2] = win[2];
    nbr[3] = win[3];
    nbr[4] = win[5];
    nbr[5] = top;
    nbr[6] = mid;
    nbr[7] = bottom;
    sum = '0;
    for (int k = 0; k < 8; k++) begin
      sum = sum + COUNT_W'(win[4] > nbr[k]);
    end
    count = sum;
  end

endmodule
`default_nettype wire

// ----- rtl/rank_transform_3x3.sv -----
// Top level of the 3x3 rank transform: position tracking, pipeline control and output register.
// The block takes one pixel per clock cycle in raster order and, for each interior cell,
// reports how many of its eight neighbors are strictly smaller than the center. The result
// for cell (r,c) leaves once pixel (r+1,c+1) is taken and has passed the registered read of
// the line store memory, which holds rows r-1 and r side by side in one entry per column,
// and then the output register. A pixel is taken in every cycle as long as results are
// drained; a stalled output holds back only the pixel behind it.
// Writing side_length restarts the position at row 0, column 0; a value above MAX_SIDE acts
// as MAX_SIDE, and a side below three gives no results.
`timescale 1ns / 1ps
`default_nettype none
module rank_transform_3x3
  import rt3_pkg::*;
#(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               config_write,
  input  wire logic [CFG_W-1:0]   config_data,
  input  wire logic               pixel_valid,
  output logic                    pixel_stall,
  input  wire logic [IN_W-1:0]    pixel_value,
  input  wire logic               frame_start,
  output logic                    cell_valid,
  input  wire logic               cell_stall,
  output logic      [COORD_W-1:0] cell_row,
  output logic      [COORD_W-1:0] cell_column,
  output logic      [COUNT_W-1:0] smaller_count,
  output logic                    last_cell
);

  localparam int POS_W = $clog2(MAX_SIDE);
  localparam int CW    = (POS_W + 1 > CFG_W) ? POS_W + 1 : CFG_W;

  logic [CFG_W-1:0] side_length;
  logic [CW-1:0]    side_eff;
  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] col_pos;
  logic [POS_W-1:0] r;
  logic [POS_W-1:0] c;
  logic [POS_W-1:0] row_pos_next;
  logic [POS_W-1:0] col_pos_next;
  logic             accept;
  logic             emit;

  logic                         s1_valid;
  logic                         s1_emit;
  logic                         s1_last;
  logic [POS_W-1:0]             s1_row;
  logic [POS_W-1:0]             s1_col;
  logic signed [PIXEL_BITS-1:0] s1_px;
  logic                         s1_adv;

  logic [2*PIXEL_BITS-1:0]      rd_data;
  logic signed [PIXEL_BITS-1:0] rd_top;
  logic signed [PIXEL_BITS-1:0] rd_mid;
  logic [COUNT_W-1:0]           count;

  assign side_eff = (CW'(side_length) > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(side_length);

  assign s1_adv      = s1_valid && (!s1_emit || !cell_valid || !cell_stall);
  assign pixel_stall = s1_valid && !s1_adv;
  assign accept      = pixel_valid && !pixel_stall;

  assign r = frame_start ? '0 : row_pos;
  assign c = frame_start ? '0 : col_pos;

  assign emit = (side_eff >= CW'(MIN_SIDE)) && (CW'(r) >= CW'(2)) && (CW'(c) >= CW'(2)) &&
                (CW'(r) < side_eff) && (CW'(c) < side_eff);

  always_comb begin
    row_pos_next = r;
    col_pos_next = c + POS_W'(1);
    if ((CW'(c) + CW'(1)) >= side_eff) begin
      col_pos_next = '0;
      if ((CW'(r) + CW'(1)) >= side_eff) begin
        row_pos_next = '0;
      end else begin
        row_pos_next = r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_length <= SIDE_RESET;
      row_pos     <= '0;
      col_pos     <= '0;
    end else if (config_write) begin
      side_length <= config_data;
      row_pos     <= '0;
      col_pos     <= '0;
    end else if (accept) begin
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit <= emit;
      s1_last <= emit && ((CW'(r) + CW'(1)) == side_eff) && ((CW'(c) + CW'(1)) == side_eff);
      s1_row  <= r;
      s1_col  <= c;
      s1_px   <= pixel_value[PIXEL_BITS-1:0];
    end
  end

  rt3_line_mem #(
    .DEPTH (MAX_SIDE),
    .WIDTH (2 * PIXEL_BITS),
    .AW    (POS_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (c),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data ({rd_mid, s1_px})
  );

  assign rd_top = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
  assign rd_mid = rd_data[PIXEL_BITS-1:0];

  rt3_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk    (clk),
    .shift  (s1_adv),
    .top    (rd_top),
    .mid    (rd_mid),
    .bottom (s1_px),
    .count  (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      cell_valid <= 1'b1;
    end else if (!cell_stall) begin
      cell_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      cell_row      <= COORD_W'(s1_row - POS_W'(1));
      cell_column   <= COORD_W'(s1_col - POS_W'(1));
      smaller_count <= count;
      last_cell     <= s1_last;
    end
  end

  // The column position never reaches the side length.
  a_col_in_range : assert property (@(posedge clk) disable iff (rst)
    (col_pos == '0) || (CW'(col_pos) < side_eff))
    else $error("column position outside the image");

  // A count never exceeds the eight neighbors.
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    cell_valid |-> (smaller_count <= COUNT_W'(8)))
    else $error("rank count above eight");

  // The last interior cell lies on the diagonal.
  a_last_diag : assert property (@(posedge clk) disable iff (rst)
    (cell_valid && last_cell) |-> (cell_row == cell_column))
    else $error("last cell off the diagonal");

  // A held pipeline stage keeps its request until it can move on.
  a_s1_hold : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_col) && $stable(s1_row)))
    else $error("stalled request lost in the pipeline");

endmodule
`default_nettype wire

// ----- tb/tb_rank_transform_3x3.sv -----
// Self-checking testbench for the 3x3 rank transform: directed frames, a maximum-side run and random frames.
`timescale 1ns / 1ps
module tb_rank_transform_3x3;
  import rt3_pkg::*;

  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS  = 700;
  localparam int QUIET_PIXELS   = 150;
  localparam int MAX_SIDE_RUN   = 64;
  localparam int MAX_PRINTS     = 20;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic [COUNT_W-1:0] count;
    logic               last;
  } cell_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               config_write = 1'b0;
  logic [CFG_W-1:0]   config_data = '0;
  logic               pixel_valid = 1'b0;
  logic               pixel_stall;
  logic [IN_W-1:0]    pixel_value = '0;
  logic               frame_start = 1'b0;
  logic               cell_valid;
  logic               cell_stall = 1'b0;
  logic [COORD_W-1:0] cell_row;
  logic [COORD_W-1:0] cell_column;
  logic [COUNT_W-1:0] smaller_count;
  logic               last_cell;

  // Model of the block state, kept in step with every accepted request.
  logic [CFG_W-1:0]       side_reg = SIDE_RESET;
  logic signed [IN_W-1:0] older_line [MAX_SIDE_DEF];
  logic signed [IN_W-1:0] newer_line [MAX_SIDE_DEF];
  logic signed [IN_W-1:0] window [6];
  int                     row_pos = 0;
  int                     col_pos = 0;
  cell_t                  expected_cells [$];

  int errors = 0;
  int pixels_sent = 0;
  int cells_checked = 0;
  int gap_odds = 6;
  int stall_odds = 6;
  int stall_left = 0;
  int idle_cycles = 0;

  rank_transform_3x3 uut (
    .clk          (clk),
    .rst          (rst),
    .config_write (config_write),
    .config_data  (config_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_value  (pixel_value),
    .frame_start  (frame_start),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .cell_row     (cell_row),
    .cell_column  (cell_column),
    .smaller_count(smaller_count),
    .last_cell    (last_cell)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    end
  endtask

  function automatic void predict_rank(input logic signed [IN_W-1:0] px, input logic fs);
    int side;
    int r;
    int c;
    int k;
    logic signed [IN_W-1:0] top;
    logic signed [IN_W-1:0] mid;
    logic signed [IN_W-1:0] nb [9];
    int n;
    cell_t next_cell;
    side = (side_reg > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(side_reg);
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    top = older_line[c];
    mid = newer_line[c];
    if (side >= MIN_SIDE && r >= 2 && c >= 2 && r < side && c < side) begin
      for (k = 0; k < 6; k++) nb[k] = window[k];
      nb[6] = top;
      nb[7] = mid;
      nb[8] = px;
      n = 0;
      for (k = 0; k < 9; k++) begin
        if (k != 4 && nb[4] > nb[k]) n++;
      end
      next_cell.row = COORD_W'(r - 1);
      next_cell.column = COORD_W'(c - 1);
      next_cell.count = COUNT_W'(n);
      next_cell.last = (r == side - 1 && c == side - 1);
      expected_cells.push_back(next_cell);
    end
    window[0] = window[3];
    window[1] = window[4];
    window[2] = window[5];
    window[3] = top;
    window[4] = mid;
    window[5] = px;
    older_line[c] = mid;
    newer_line[c] = px;
    if (c + 1 >= side) begin
      col_pos = 0;
      row_pos = (r + 1 >= side) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic send_pixel(input logic [IN_W-1:0] px, input logic fs);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_value <= px;
    frame_start <= fs;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    predict_rank(px, fs);
    pixels_sent++;
  endtask

  task automatic wait_drained();
    pixel_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side(input logic [CFG_W-1:0] value);
    wait_drained();
    config_write <= 1'b1;
    config_data <= value;
    @(posedge clk);
    config_write <= 1'b0;
    side_reg = value;
    row_pos = 0;
    col_pos = 0;
  endtask

  function automatic logic [IN_W-1:0] pick_pixel(input int mode);
    case (mode)
      0: return IN_W'($urandom_range(0, 4) - 2);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return IN_W'($urandom);
    endcase
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 4;
      default: return 16;
    endcase
  endfunction

  task automatic send_run(input int count, input logic fs_first, input int mode,
                          input int fs_odds);
    int i;
    logic fs;
    for (i = 0; i < count; i++) begin
      fs = (i == 0 && fs_first) || (fs_odds != 0 && $urandom_range(1, fs_odds) == 1);
      send_pixel(pick_pixel(mode), fs);
    end
  endtask

  task automatic send_frame3(input logic [IN_W-1:0] vals [9], input logic fs_first);
    int i;
    for (i = 0; i < 9; i++) send_pixel(vals[i], fs_first && i == 0);
  endtask

  // The maximum count, then the minimum with ties, after an aborted frame start.
  task automatic test_count_extremes();
    logic [IN_W-1:0] frame_high [9];
    logic [IN_W-1:0] frame_low [9];
    frame_high = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF,
                   16'h8000, 16'h8000, 16'h8000, 16'h8000};
    frame_low = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                  16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
    send_pixel(16'h1234, 1'b1);
    send_pixel(16'hFEDC, 1'b0);
    send_frame3(frame_high, 1'b1);
    send_frame3(frame_low, 1'b0);
  endtask

  // Sides below three must advance the position without producing results.
  task automatic test_small_sides();
    write_side(CFG_W'(2));
    send_run(4, 1'b1, 2, 0);
    write_side(CFG_W'(1));
    send_run(2, 1'b0, 2, 0);
  endtask

  // An oversized side acts as the maximum; the start of the first row gives no results.
  task automatic test_max_side();
    write_side(CFG_W'(2047));
    send_run(MAX_SIDE_RUN, 1'b1, 2, 0);
  endtask

  task automatic test_random_frames();
    int start;
    int n;
    int frames;
    int kind;
    int mode;
    int k;
    logic [CFG_W-1:0] side;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      if (pixels_sent - start >= RANDOM_PIXELS - QUIET_PIXELS) begin
        gap_odds = 0;
        stall_odds = 0;
      end else begin
        gap_odds = pick_odds();
        stall_odds = pick_odds();
      end
      case ($urandom_range(0, 19))
        0: side = CFG_W'($urandom_range(1, 2));
        1: side = CFG_W'($urandom_range(9, 16));
        default: side = CFG_W'($urandom_range(3, 8));
      endcase
      write_side(side);
      n = int'(side) * int'(side);
      frames = $urandom_range(1, 3);
      for (k = 0; k < frames; k++) begin
        kind = $urandom_range(0, 9);
        mode = $urandom_range(0, 3);
        if (kind == 0) begin
          send_run($urandom_range(1, (n > 1) ? n - 1 : 1), 1'b1, mode, 0);
        end else if (kind == 1) begin
          send_run(n, 1'b1, mode, 4);
        end else begin
          send_run(n, $urandom_range(0, 3) != 0, mode, 0);
        end
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst || stall_odds == 0) begin
      cell_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      cell_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      cell_stall <= 1'b0;
      if ($urandom_range(1, stall_odds) == 1) stall_left <= $urandom_range(1, 15);
    end
  end

  always @(posedge clk) begin
    cell_t want;
    if (!rst && cell_valid && !cell_stall) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("cell with no request behind it, row", cell_row, 0);
      end else begin
        want = expected_cells.pop_front();
        cells_checked++;
        if (cell_row !== want.row) report_mismatch("cell_row", cell_row, want.row);
        if (cell_column !== want.column) begin
          report_mismatch("cell_column", cell_column, want.column);
        end
        if (smaller_count !== want.count) begin
          report_mismatch("smaller_count", smaller_count, want.count);
        end
        if (last_cell !== want.last) report_mismatch("last_cell", last_cell, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (cell_valid && !cell_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_count_extremes();
    test_small_sides();
    test_max_side();
    test_random_frames();
    wait_drained();
    $display("Sent %0d pixels and checked %0d cells over sides 1 to 2047.",
             pixels_sent, cells_checked);
    $display("Frames were whole, wrapped, cut short and restarted, with random stalls.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rt3_pkg.sv
rtl/rt3_line_mem.sv
rtl/rt3_window.sv
rtl/rank_transform_3x3.sv
tb/tb_rank_transform_3x3.sv
